### sv/tlct_pkg.sv
`timescale 1ns / 1ps

package tlct_pkg;

  // phase resolution of the sine evaluation, 6 to 14
  localparam int TRIG_TABLE_BITS = 10;
  localparam int QUARTER_BITS    = TRIG_TABLE_BITS - 2;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_POS_GAIN1  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POS_GAIN2  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RATE_GAIN1 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RATE_GAIN2 = 2'd3;

  localparam logic [15:0] POS_GAIN_RST  = 16'd512;
  localparam logic [15:0] RATE_GAIN_RST = 16'd77;

  // 1/(2*pi) in Q32
  localparam logic signed [30:0] INV_TWO_PI = 31'sd683565276;

  // odd sine polynomial, Q30
  localparam logic [30:0] SIN_C1  = 31'd1686629713;
  localparam logic [30:0] SIN_C3  = 31'd693598668;
  localparam logic [30:0] SIN_C5  = 31'd85569306;
  localparam logic [30:0] SIN_C7  = 31'd5026995;
  localparam logic [31:0] ONE_Q30 = 32'd1073741824;

  // arm dynamics, Q40 (mass and Coriolis) and Q30 (gravity)
  localparam logic signed [35:0] M00_BASE  = 36'sd6936954100;
  localparam logic signed [35:0] M01_BASE  = 36'sd934914737;
  localparam logic signed [35:0] M11_BASE  = 36'sd934914737;
  localparam logic signed [31:0] COUPLE_H  = 32'sd1963320948;
  localparam logic signed [31:0] GRAV_ONE  = 32'sd548119542;
  localparam logic signed [31:0] GRAV_TWO  = 32'sd89565564;

endpackage

### sv/tlct_sine.sv
`timescale 1ns / 1ps

// Pipelined sine of a quantized phase; the result is registered.
module tlct_sine (
  input  logic                                 clk,
  input  logic [tlct_pkg::TRIG_TABLE_BITS-1:0] phase,
  output logic signed [31:0]                   sine
);
  import tlct_pkg::*;

  localparam int XSHIFT = 30 - QUARTER_BITS;

  logic [QUARTER_BITS:0] r_c;
  logic [30:0]           x_c;

  logic [30:0] x_r1, x_r2, x_r3, x_r4, x_r5;
  logic        n_r1, n_r2, n_r3, n_r4, n_r5, n_r6;
  logic [61:0] x2p_r2;
  logic [30:0] x2_r3, x2_r4;
  logic [53:0] p7_r3;
  logic [61:0] p5_r4, p3_r5, p1_r6;
  logic signed [31:0] sine_r;

  logic [30:0] t5_c, t3_c, t1_c;
  logic [31:0] s_c;

  always_comb begin
    r_c = {1'b0, phase[QUARTER_BITS-1:0]};
    // mirror within quadrants one and three
    if (phase[QUARTER_BITS]) begin
      r_c = (QUARTER_BITS+1)'(1 << QUARTER_BITS) - r_c;
    end
    x_c  = {r_c, {XSHIFT{1'b0}}};
    t5_c = SIN_C5 - 31'(p7_r3 >> 30);
    t3_c = SIN_C3 - 31'(p5_r4 >> 30);
    t1_c = SIN_C1 - 31'(p3_r5 >> 30);
    s_c  = 32'(p1_r6 >> 30);
    if (s_c > ONE_Q30) begin
      s_c = ONE_Q30;
    end
  end

  always_ff @(posedge clk) begin
    x_r1   <= x_c;
    n_r1   <= phase[TRIG_TABLE_BITS-1];
    x2p_r2 <= x_r1 * x_r1;
    x_r2   <= x_r1;
    n_r2   <= n_r1;
    x2_r3  <= x2p_r2[60:30];
    p7_r3  <= x2p_r2[60:30] * SIN_C7[22:0];
    x_r3   <= x_r2;
    n_r3   <= n_r2;
    p5_r4  <= x2_r3 * t5_c;
    x2_r4  <= x2_r3;
    x_r4   <= x_r3;
    n_r4   <= n_r3;
    p3_r5  <= x2_r4 * t3_c;
    x_r5   <= x_r4;
    n_r5   <= n_r4;
    p1_r6  <= x_r5 * t1_c;
    n_r6   <= n_r5;
    sine_r <= n_r6 ? -$signed(s_c) : $signed(s_c);
  end

  assign sine = sine_r;

endmodule

### sv/two_link_computed_torque.sv
`timescale 1ns / 1ps

// Computed-torque controller with PD correction for a two-joint planar arm.
// Input: pulse start with the ten in_* fields; busy is always low, so an
// item is taken in every cycle that start is high. Throughput is one item
// per clock.
// Output: out_valid is high for one cycle with out_torque_joint1/2 and
// out_saturated for each item taken, once it leaves the pipeline. The receiver
// cannot stall; results appear in input order. Each item passes through the
// seven-stage sine pipeline (five chained multiplies) followed by the
// dynamics chain: matrix terms, products with the targets, and a two-level
// adder tree with rounding and saturation.
// Configuration: cfg_valid/cfg_ready write cfg_data to register cfg_index
// (0 Kp1, 1 Kp2, 2 Kd1, 3 Kd2, unsigned Q8.8); cfg_ready is always high.
// Gains are read live, so write them only while no item is in flight.
// Reset (rst_n low, synchronous) restores the default gains and drops
// every item in flight.
module two_link_computed_torque (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic signed [15:0]               in_joint1_angle,
  input  logic signed [15:0]               in_joint2_angle,
  input  logic signed [15:0]               in_joint1_rate,
  input  logic signed [15:0]               in_joint2_rate,
  input  logic signed [15:0]               in_target1_angle,
  input  logic signed [15:0]               in_target2_angle,
  input  logic signed [15:0]               in_target1_rate,
  input  logic signed [15:0]               in_target2_rate,
  input  logic signed [15:0]               in_target1_accel,
  input  logic signed [15:0]               in_target2_accel,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [tlct_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [15:0]                      cfg_data,
  output logic                             out_valid,
  output logic signed [15:0]               out_torque_joint1,
  output logic signed [15:0]               out_torque_joint2,
  output logic                             out_saturated
);
  import tlct_pkg::*;

  localparam int B      = TRIG_TABLE_BITS;
  localparam int NSIDE  = 11;
  localparam int NVLD   = 15;
  localparam int RBIT   = 43 - B;

  typedef struct packed {
    logic signed [15:0] w1;
    logic signed [15:0] w2;
    logic signed [15:0] tw1;
    logic signed [15:0] tw2;
    logic signed [15:0] ta1;
    logic signed [15:0] ta2;
    logic signed [16:0] dq1;
    logic signed [16:0] dq2;
    logic signed [16:0] dw1;
    logic signed [16:0] dw2;
  } side_t;

  logic [15:0] kp1_r, kp2_r, kd1_r, kd2_r;
  logic [NVLD-1:0] vld_r;
  side_t side_r [NSIDE];
  side_t side_nxt;

  logic signed [16:0] q12_c;
  logic signed [47:0] ph1_c, ph2_c, ph12_c;
  logic [43:0] ph1_r, ph2_r, ph12_r;
  logic [43:0] u1_c, u2_c, u12_c;
  logic [B-1:0] p1_c, p2_c, p12_c;
  logic [B-1:0] pc1_c, pc2_c, pc12_c;
  logic signed [31:0] c1_s, c2_s, s2_s, c12_s;

  // P1
  logic signed [63:0] pc2_r, ps2_r, pg1_r, pg2_r;
  logic signed [33:0] kp1t_r, kp2t_r, kd1t_r, kd2t_r;
  // P2
  logic signed [35:0] m00_r, m01_r;
  logic signed [32:0] hs_r;
  // gravity is Q40, up to about 0.6 Nm
  logic signed [41:0] g0_r, g1_r;
  logic signed [33:0] kp1t_r2, kp2t_r2, kd1t_r2, kd2t_r2;
  // P3
  logic signed [16:0] wsum_c;
  logic signed [51:0] mt00_r, mt01_r, mt10_r, mt11_r;
  logic signed [48:0] hp00_r, hp10_r;
  logic signed [49:0] hp01_r;
  logic signed [41:0] g0_r3, g1_r3;
  logic signed [33:0] kp1t_r3, kp2t_r3, kd1t_r3, kd2t_r3;
  // P4
  logic signed [50:0] n00_c, n01_c;
  logic signed [41:0] k00_c, k01_c, k10_c;
  logic signed [57:0] kt00_r, kt01_r, kt10_r;
  logic signed [43:0] m00t_r, m01t_r, m10t_r, m11t_r;
  logic signed [41:0] g0_r4, g1_r4;
  logic signed [33:0] kp1t_r4, kp2t_r4, kd1t_r4, kd2t_r4;
  // P5, P6
  logic signed [63:0] a0_r, b0_r, e0_r, a1_r, b1_r, e1_r;
  logic signed [63:0] acc0_r, acc1_r;
  // P7
  logic signed [33:0] v0_c, v1_c;
  logic signed [15:0] t0_c, t1_c;
  logic clip0_c, clip1_c;
  logic signed [15:0] tq1_r, tq2_r;
  logic sat_r;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp1_r <= POS_GAIN_RST;
      kp2_r <= POS_GAIN_RST;
      kd1_r <= RATE_GAIN_RST;
      kd2_r <= RATE_GAIN_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_POS_GAIN1:  kp1_r <= cfg_data;
        REG_POS_GAIN2:  kp2_r <= cfg_data;
        REG_RATE_GAIN1: kd1_r <= cfg_data;
        REG_RATE_GAIN2: kd2_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[NVLD-2:0], start && !busy};
    end
  end

  // entry: phase products and errors
  always_comb begin
    q12_c  = 17'(in_joint1_angle) + 17'(in_joint2_angle);
    ph1_c  = in_joint1_angle * INV_TWO_PI;
    ph2_c  = in_joint2_angle * INV_TWO_PI;
    ph12_c = q12_c * INV_TWO_PI;
    side_nxt.w1  = in_joint1_rate;
    side_nxt.w2  = in_joint2_rate;
    side_nxt.tw1 = in_target1_rate;
    side_nxt.tw2 = in_target2_rate;
    side_nxt.ta1 = in_target1_accel;
    side_nxt.ta2 = in_target2_accel;
    side_nxt.dq1 = 17'(in_target1_angle) - 17'(in_joint1_angle);
    side_nxt.dq2 = 17'(in_target2_angle) - 17'(in_joint2_angle);
    side_nxt.dw1 = 17'(in_target1_rate) - 17'(in_joint1_rate);
    side_nxt.dw2 = 17'(in_target2_rate) - 17'(in_joint2_rate);
  end

  always_ff @(posedge clk) begin
    ph1_r     <= ph1_c[43:0];
    ph2_r     <= ph2_c[43:0];
    ph12_r    <= ph12_c[43:0];
    side_r[0] <= side_nxt;
    for (int i = 1; i < NSIDE; i++) begin
      side_r[i] <= side_r[i-1];
    end
  end

  // round to phase steps; cosine is sine a quarter turn ahead
  always_comb begin
    u1_c   = ph1_r + (44'(1) << RBIT);
    u2_c   = ph2_r + (44'(1) << RBIT);
    u12_c  = ph12_r + (44'(1) << RBIT);
    p1_c   = u1_c[43:44-B];
    p2_c   = u2_c[43:44-B];
    p12_c  = u12_c[43:44-B];
    pc1_c  = p1_c + B'(1 << QUARTER_BITS);
    pc2_c  = p2_c + B'(1 << QUARTER_BITS);
    pc12_c = p12_c + B'(1 << QUARTER_BITS);
  end

  tlct_sine u_cos1  (.clk(clk), .phase(pc1_c),  .sine(c1_s));
  tlct_sine u_cos2  (.clk(clk), .phase(pc2_c),  .sine(c2_s));
  tlct_sine u_sin2  (.clk(clk), .phase(p2_c),   .sine(s2_s));
  tlct_sine u_cos12 (.clk(clk), .phase(pc12_c), .sine(c12_s));

  always_comb begin
    wsum_c = 17'(side_r[9].w1) + 17'(side_r[9].w2);
    n00_c  = -(51'(hp00_r));
    n01_c  = -(51'(hp01_r));
    k00_c  = 42'(n00_c >>> 8);
    k01_c  = 42'(n01_c >>> 8);
    k10_c  = 42'(hp10_r >>> 8);
  end

  always_ff @(posedge clk) begin
    // P1
    pc2_r  <= COUPLE_H * c2_s;
    ps2_r  <= COUPLE_H * s2_s;
    pg1_r  <= GRAV_ONE * c1_s;
    pg2_r  <= GRAV_TWO * c12_s;
    kp1t_r <= $signed({1'b0, kp1_r}) * side_r[7].dq1;
    kp2t_r <= $signed({1'b0, kp2_r}) * side_r[7].dq2;
    kd1t_r <= $signed({1'b0, kd1_r}) * side_r[7].dw1;
    kd2t_r <= $signed({1'b0, kd2_r}) * side_r[7].dw2;
    // P2
    m00_r   <= M00_BASE + 36'(pc2_r >>> 29);
    m01_r   <= M01_BASE + 36'(pc2_r >>> 30);
    hs_r    <= 33'(ps2_r >>> 30);
    g0_r    <= 42'(pg1_r >>> 20) + 42'(pg2_r >>> 20);
    g1_r    <= 42'(pg2_r >>> 20);
    kp1t_r2 <= kp1t_r;
    kp2t_r2 <= kp2t_r;
    kd1t_r2 <= kd1t_r;
    kd2t_r2 <= kd2t_r;
    // P3
    mt00_r  <= m00_r * side_r[9].ta1;
    mt01_r  <= m01_r * side_r[9].ta2;
    mt10_r  <= m01_r * side_r[9].ta1;
    mt11_r  <= M11_BASE * side_r[9].ta2;
    hp00_r  <= hs_r * side_r[9].w2;
    hp01_r  <= hs_r * wsum_c;
    hp10_r  <= hs_r * side_r[9].w1;
    g0_r3   <= g0_r;
    g1_r3   <= g1_r;
    kp1t_r3 <= kp1t_r2;
    kp2t_r3 <= kp2t_r2;
    kd1t_r3 <= kd1t_r2;
    kd2t_r3 <= kd2t_r2;
    // P4
    kt00_r  <= k00_c * side_r[10].tw1;
    kt01_r  <= k01_c * side_r[10].tw2;
    kt10_r  <= k10_c * side_r[10].tw1;
    m00t_r  <= 44'(mt00_r >>> 8);
    m01t_r  <= 44'(mt01_r >>> 8);
    m10t_r  <= 44'(mt10_r >>> 8);
    m11t_r  <= 44'(mt11_r >>> 8);
    g0_r4   <= g0_r3;
    g1_r4   <= g1_r3;
    kp1t_r4 <= kp1t_r3;
    kp2t_r4 <= kp2t_r3;
    kd1t_r4 <= kd1t_r3;
    kd2t_r4 <= kd2t_r3;
    // P5
    a0_r <= 64'(m00t_r) + 64'(m01t_r);
    b0_r <= 64'(kt00_r >>> 8) + 64'(kt01_r >>> 8);
    e0_r <= (64'(kp1t_r4) <<< 20) + (64'(kd1t_r4) <<< 24) - 64'(g0_r4);
    a1_r <= 64'(m10t_r) + 64'(m11t_r);
    b1_r <= 64'(kt10_r >>> 8);
    e1_r <= (64'(kp2t_r4) <<< 20) + (64'(kd2t_r4) <<< 24) - 64'(g1_r4);
    // P6
    acc0_r <= a0_r + b0_r + e0_r;
    acc1_r <= a1_r + b1_r + e1_r;
    // P7
    tq1_r <= t0_c;
    tq2_r <= t1_c;
    sat_r <= clip0_c || clip1_c;
  end

  // round half up to Q10, then clip
  always_comb begin
    v0_c    = 34'((acc0_r + (64'sd1 <<< 29)) >>> 30);
    v1_c    = 34'((acc1_r + (64'sd1 <<< 29)) >>> 30);
    clip0_c = 1'b1;
    clip1_c = 1'b1;
    if (v0_c > 34'sd32767) begin
      t0_c = 16'sh7FFF;
    end else if (v0_c < -34'sd32768) begin
      t0_c = 16'sh8000;
    end else begin
      t0_c    = v0_c[15:0];
      clip0_c = 1'b0;
    end
    if (v1_c > 34'sd32767) begin
      t1_c = 16'sh7FFF;
    end else if (v1_c < -34'sd32768) begin
      t1_c = 16'sh8000;
    end else begin
      t1_c    = v1_c[15:0];
      clip1_c = 1'b0;
    end
  end

  assign out_valid         = vld_r[NVLD-1];
  assign out_torque_joint1 = tq1_r;
  assign out_torque_joint2 = tq2_r;
  assign out_saturated     = sat_r;

  a_out_follows_item: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[NVLD-1] |-> $past(vld_r[7], 7))
    else $error("result without matching item");

  a_sat_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_saturated) |->
      (out_torque_joint1 == 16'sh7FFF || out_torque_joint1 == 16'sh8000 ||
       out_torque_joint2 == 16'sh7FFF || out_torque_joint2 == 16'sh8000))
    else $error("saturation flag without clipped torque");

  a_cfg_write: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_valid && cfg_ready && cfg_index == REG_POS_GAIN1) |=>
      (kp1_r == $past(cfg_data)))
    else $error("gain write lost");

endmodule

### test/tlct_checker.sv
`timescale 1ns / 1ps

module tlct_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  logic signed [15:0] q1_in,
  input  logic signed [15:0] q2_in,
  input  logic signed [15:0] w1_in,
  input  logic signed [15:0] w2_in,
  input  logic signed [15:0] tq1_in,
  input  logic signed [15:0] tq2_in,
  input  logic signed [15:0] tw1_in,
  input  logic signed [15:0] tw2_in,
  input  logic signed [15:0] ta1_in,
  input  logic signed [15:0] ta2_in,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [tlct_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               out_valid,
  input  logic signed [15:0] out_t1,
  input  logic signed [15:0] out_t2,
  input  logic               out_sat,
  output int                 pending,
  output int                 failures
);
  import tlct_pkg::*;

  typedef struct packed {
    logic signed [15:0] t1;
    logic signed [15:0] t2;
    logic               sat;
  } torque_t;

  torque_t torque_q[$];
  logic [15:0] kp1, kp2, kd1, kd2;

  localparam longint PHASE_MASK = (64'd1 << TRIG_TABLE_BITS) - 1;

  function automatic logic [63:0] angle_phase(longint a);
    longint prod;
    logic [63:0] u;
    prod = a * longint'(INV_TWO_PI);
    u = prod + (64'd1 << (43 - TRIG_TABLE_BITS));
    return (u >> (44 - TRIG_TABLE_BITS)) & PHASE_MASK;
  endfunction

  function automatic longint sine_q30(logic [63:0] p);
    logic [63:0] quad, r, quarter;
    longint x, x2, t, s;
    quarter = 64'd1 << QUARTER_BITS;
    quad = (p >> QUARTER_BITS) & 64'd3;
    r = p & (quarter - 1);
    if (quad[0]) r = quarter - r;
    x = longint'(r << (30 - QUARTER_BITS));
    x2 = (x * x) >>> 30;
    t = longint'(SIN_C5) - ((x2 * longint'(SIN_C7)) >>> 30);
    t = longint'(SIN_C3) - ((x2 * t) >>> 30);
    t = longint'(SIN_C1) - ((x2 * t) >>> 30);
    s = (x * t) >>> 30;
    if (s > longint'(ONE_Q30)) s = longint'(ONE_Q30);
    return quad[1] ? -s : s;
  endfunction

  function automatic longint cosine_q30(logic [63:0] p);
    return sine_q30(p + (64'd1 << QUARTER_BITS));
  endfunction

  // round half up Q40 -> Q10, then clip to 16 bits
  function automatic logic signed [15:0] round_clip(longint acc, inout logic clip);
    longint v;
    v = (acc + (longint'(1) << 29)) >>> 30;
    if (v > 32767) begin
      clip = 1'b1;
      return 16'sd32767;
    end
    if (v < -32768) begin
      clip = 1'b1;
      return -16'sd32768;
    end
    return v[15:0];
  endfunction

  function automatic torque_t predict_torque();
    longint q1, q2, w1, w2, tq1, tq2, tw1, tw2, ta1, ta2;
    longint c1, c2, s2, c12, m00, m01, m11, hs, k00, k01, k10, g0, g1, acc0, acc1;
    longint ch;
    torque_t r;
    logic clip;
    q1 = q1_in; q2 = q2_in; w1 = w1_in; w2 = w2_in;
    tq1 = tq1_in; tq2 = tq2_in; tw1 = tw1_in; tw2 = tw2_in;
    ta1 = ta1_in; ta2 = ta2_in;
    ch = longint'(COUPLE_H);
    c1 = cosine_q30(angle_phase(q1));
    c2 = cosine_q30(angle_phase(q2));
    s2 = sine_q30(angle_phase(q2));
    c12 = cosine_q30(angle_phase(q1 + q2));
    m00 = longint'(M00_BASE) + ((2 * ch * c2) >>> 30);
    m01 = longint'(M01_BASE) + ((ch * c2) >>> 30);
    m11 = longint'(M11_BASE);
    hs = (ch * s2) >>> 30;
    k00 = (-hs * w2) >>> 8;
    k01 = (-hs * (w1 + w2)) >>> 8;
    k10 = (hs * w1) >>> 8;
    g1 = (longint'(GRAV_TWO) * c12) >>> 20;
    g0 = ((longint'(GRAV_ONE) * c1) >>> 20) + g1;
    acc0 = ((m00 * ta1) >>> 8) + ((m01 * ta2) >>> 8) + ((k00 * tw1) >>> 8)
         + ((k01 * tw2) >>> 8) - g0
         + longint'(kp1) * (tq1 - q1) * (longint'(1) << 20)
         + longint'(kd1) * (tw1 - w1) * (longint'(1) << 24);
    acc1 = ((m01 * ta1) >>> 8) + ((m11 * ta2) >>> 8) + ((k10 * tw1) >>> 8) - g1
         + longint'(kp2) * (tq2 - q2) * (longint'(1) << 20)
         + longint'(kd2) * (tw2 - w2) * (longint'(1) << 24);
    clip = 1'b0;
    r.t1 = round_clip(acc0, clip);
    r.t2 = round_clip(acc1, clip);
    r.sat = clip;
    return r;
  endfunction

  initial begin
    failures = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    torque_t e;
    if (!rst_n) begin
      kp1 = POS_GAIN_RST;
      kp2 = POS_GAIN_RST;
      kd1 = RATE_GAIN_RST;
      kd2 = RATE_GAIN_RST;
    end else begin
      if (out_valid) begin
        if (torque_q.size() == 0) begin
          $error("unexpected result: t1=%0d t2=%0d sat=%0b", out_t1, out_t2, out_sat);
          failures++;
        end else begin
          e = torque_q.pop_front();
          if (out_t1 !== e.t1) begin
            $error("torque_joint1: expected %0d, got %0d", e.t1, out_t1);
            failures++;
          end
          if (out_t2 !== e.t2) begin
            $error("torque_joint2: expected %0d, got %0d", e.t2, out_t2);
            failures++;
          end
          if (out_sat !== e.sat) begin
            $error("saturated: expected %0b, got %0b", e.sat, out_sat);
            failures++;
          end
        end
      end
      if (start && !busy) torque_q.push_back(predict_torque());
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_POS_GAIN1:  kp1 = cfg_data;
          REG_POS_GAIN2:  kp2 = cfg_data;
          REG_RATE_GAIN1: kd1 = cfg_data;
          REG_RATE_GAIN2: kd2 = cfg_data;
          default: ;
        endcase
      end
    end
    pending = torque_q.size();
  end

endmodule

### test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import tlct_pkg::*;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  logic signed [15:0] stim [10];
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [15:0] cfg_data;
  logic out_valid;
  logic signed [15:0] out_t1, out_t2;
  logic out_sat;
  int pending, failures;

  two_link_computed_torque i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_joint1_angle(stim[0]), .in_joint2_angle(stim[1]),
    .in_joint1_rate(stim[2]), .in_joint2_rate(stim[3]),
    .in_target1_angle(stim[4]), .in_target2_angle(stim[5]),
    .in_target1_rate(stim[6]), .in_target2_rate(stim[7]),
    .in_target1_accel(stim[8]), .in_target2_accel(stim[9]),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .out_valid(out_valid), .out_torque_joint1(out_t1),
    .out_torque_joint2(out_t2), .out_saturated(out_sat)
  );

  tlct_checker i_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .q1_in(stim[0]), .q2_in(stim[1]), .w1_in(stim[2]), .w2_in(stim[3]),
    .tq1_in(stim[4]), .tq2_in(stim[5]), .tw1_in(stim[6]), .tw2_in(stim[7]),
    .ta1_in(stim[8]), .ta2_in(stim[9]),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .out_valid(out_valid), .out_t1(out_t1),
    .out_t2(out_t2), .out_sat(out_sat), .pending(pending), .failures(failures)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

  task automatic send_item(input logic signed [15:0] v [10]);
    int gap;
    gap = $urandom_range(0, 15);
    if ($urandom_range(0, 3) == 0) gap = 0;
    repeat (gap) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start <= 1'b1;
    for (int i = 0; i < 10; i++) stim[i] <= v[i];
    do @(posedge clk); while (busy);
  endtask

  task automatic write_gain(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] d);
    @(negedge clk);
    start <= 1'b0;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // let the pipeline empty before touching the gains
  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic send_fill(input logic signed [15:0] a);
    logic signed [15:0] v [10];
    foreach (v[i]) v[i] = a;
    send_item(v);
  endtask

  task automatic send_random();
    logic signed [15:0] v [10];
    int mode;
    mode = $urandom_range(0, 2);
    foreach (v[i]) begin
      if (mode == 0) v[i] = 16'($urandom);
      else if (i < 2 || i == 4 || i == 5) v[i] = 16'($urandom_range(0, 51472) - 25736);
      else v[i] = 16'($urandom_range(0, 2047) - 1024);
    end
    send_item(v);
  endtask

  task automatic random_phase(input int n);
    repeat (n) send_random();
    drain();
  endtask

  initial begin
    logic signed [15:0] v [10];
    rst_n = 1'b0;
    start = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    foreach (stim[i]) stim[i] = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: extremes, zero, pi-ish angles, angle-sum wrap, saturation
    send_fill(16'sd0);
    send_fill(16'sd32767);
    send_fill(-16'sd32768);
    send_fill(-16'sd1);
    send_fill(16'sd1);
    foreach (v[i]) v[i] = '0;
    v[0] = 16'sd12868; v[1] = 16'sd12868; send_item(v);
    v[0] = -16'sd12868; v[1] = 16'sd6434; send_item(v);
    v[0] = 16'sd32767; v[1] = 16'sd32767; send_item(v);
    v[0] = -16'sd32768; v[1] = -16'sd32768; send_item(v);
    v[0] = 16'sd6434; v[1] = -16'sd6434; v[8] = 16'sd32767; v[9] = -16'sd32768;
    send_item(v);
    foreach (v[i]) v[i] = (i % 2) ? 16'sd32767 : -16'sd32768;
    send_item(v);
    foreach (v[i]) v[i] = (i % 2) ? -16'sd32768 : 16'sd32767;
    send_item(v);
    foreach (v[i]) v[i] = 16'sd100;
    v[2] = 16'sd32767; v[3] = 16'sd32767; v[6] = -16'sd32768; v[7] = 16'sd32767;
    send_item(v);
    drain();

    random_phase(400);

    write_gain(REG_POS_GAIN1, 16'd0);
    write_gain(REG_POS_GAIN2, 16'd0);
    write_gain(REG_RATE_GAIN1, 16'd0);
    write_gain(REG_RATE_GAIN2, 16'd0);
    random_phase(300);

    write_gain(REG_POS_GAIN1, 16'hFFFF);
    write_gain(REG_POS_GAIN2, 16'hFFFF);
    write_gain(REG_RATE_GAIN1, 16'hFFFF);
    write_gain(REG_RATE_GAIN2, 16'hFFFF);
    random_phase(300);

    repeat (3) begin
      write_gain(REG_POS_GAIN1, 16'($urandom));
      write_gain(REG_POS_GAIN2, 16'($urandom));
      write_gain(REG_RATE_GAIN1, 16'($urandom_range(0, 255)));
      write_gain(REG_RATE_GAIN2, 16'($urandom));
      random_phase(200);
    end

    if (failures == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule
